// ===== sv/csag_pkg.sv =====
// ----------------------------------------------------------------------------
// csag_pkg
// Shared types, constants and the sine table builder for the chirp sweep
// acceleration generator.
// ----------------------------------------------------------------------------
package csag_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_DEPTH     = 1024;
  localparam int SINE_ADDR_BITS = $clog2(SINE_DEPTH);
  localparam int SINE_W         = 16;
  localparam int OUT_BITS       = 16;
  localparam int TOP_BITS       = SINE_ADDR_BITS + 2;

  localparam int INC_W   = 32;
  localparam int AMP_W   = 16;
  localparam int TICK_W  = 24;
  localparam int AXIS_W  = 2;
  localparam int YAW_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // datapath widths
  localparam int SIN_W      = SINE_W + 1;           // signed sine
  localparam int PROD_W     = SIN_W + AMP_W + 1;    // sine * amplitude
  localparam int V_W        = PROD_W - 15;          // scaled sample
  localparam int ROT_PROD_W = YAW_W + V_W;          // yaw * sample
  localparam int ROT_SUM_W  = ROT_PROD_W + 2;
  localparam int ROUND_W    = ROT_SUM_W - 15;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_INC  = 3'd0,
    REG_INC_STEP   = 3'd1,
    REG_AMPLITUDE  = 3'd2,
    REG_DURATION   = 3'd3,
    REG_SCAN_AXIS  = 3'd4,
    REG_YAW_COS    = 3'd5,
    REG_YAW_SIN    = 3'd6
  } reg_idx_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic [INC_W-1:0]  start_increment;
    logic [INC_W-1:0]  increment_step;
    logic [TICK_W-1:0] duration_ticks;
  } front_cfg_t;

  typedef struct packed {
    logic [AMP_W-1:0]         amplitude;
    logic [AXIS_W-1:0]        scan_axis;
    logic signed [YAW_W-1:0]  yaw_cos;
    logic signed [YAW_W-1:0]  yaw_sin;
  } back_cfg_t;

  typedef struct packed {
    logic                done;
    logic [TOP_BITS-1:0] phase_top;
  } queue_entry_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  // Quarter-wave entry from a Q30 Taylor series, rounded to Q15.
  function automatic logic [SINE_W-1:0] make_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (PI_HALF_Q30 * (64'(2 * i) + 64'd1)) / 64'(2 * SINE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 0; k < 8; k++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[k];
      if ((k & 1) == 0) sum = sum - term;
      else sum = sum + term;
    end
    r = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) r = 64'd32767;
    return r[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int unsigned i = 0; i < SINE_DEPTH; i++) t[i] = make_entry(i);
    return t;
  endfunction

  localparam logic signed [ROUND_W-1:0] OUT_MAX = ROUND_W'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [ROUND_W-1:0] OUT_MIN = -OUT_MAX - ROUND_W'(1);

  function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [ROUND_W-1:0] v);
    logic [OUT_BITS-1:0] res;
    if (v > OUT_MAX) res = OUT_MAX[OUT_BITS-1:0];
    else if (v < OUT_MIN) res = OUT_MIN[OUT_BITS-1:0];
    else res = v[OUT_BITS-1:0];
    return res;
  endfunction

endpackage

// ===== sv/csag_in_if.sv =====
// ----------------------------------------------------------------------------
// csag_in_if
// Tick channel: one item per tick, carrying the restart flag.
// ----------------------------------------------------------------------------
interface csag_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== sv/csag_out_if.sv =====
// ----------------------------------------------------------------------------
// csag_out_if
// Result channel: three saturated acceleration axes and the done flag.
// ----------------------------------------------------------------------------
interface csag_out_if;
  import csag_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] accel_x;
  logic [OUT_BITS-1:0] accel_y;
  logic [OUT_BITS-1:0] accel_z;
  logic                sweep_done;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output sweep_done, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  input sweep_done, output ready);
endinterface

// ===== sv/csag_cfg_if.sv =====
// ----------------------------------------------------------------------------
// csag_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface csag_cfg_if;
  import csag_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/csag_front.sv =====
// ----------------------------------------------------------------------------
// csag_front
// Accepts ticks, keeps the sweep state (phase, increment, tick count) and
// queues one work entry per tick that produces a result.
// ----------------------------------------------------------------------------
module csag_front (
  input  logic                  clk,
  input  logic                  rst_n,
  csag_in_if.sink               in_ch,
  input  csag_pkg::front_cfg_t  cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output csag_pkg::queue_entry_t q_entry
);
  import csag_pkg::*;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] inc_r, inc_nxt;
  logic [TICK_W-1:0]     elapsed_r, elapsed_nxt;
  logic                  running_r, running_nxt;

  logic [PHASE_BITS-1:0] phase_e;
  logic [PHASE_BITS-1:0] inc_e;
  logic [TICK_W-1:0]     elapsed_e;
  logic                  run_e;
  logic                  accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    phase_e   = in_ch.restart ? '0 : phase_r;
    inc_e     = in_ch.restart ? PHASE_BITS'(cfg.start_increment) : inc_r;
    elapsed_e = in_ch.restart ? '0 : elapsed_r;
    run_e     = in_ch.restart || running_r;

    phase_nxt   = phase_r;
    inc_nxt     = inc_r;
    elapsed_nxt = elapsed_r;
    running_nxt = running_r;
    q_push      = 1'b0;
    q_entry     = '0;

    if (accept && run_e) begin
      q_push      = 1'b1;
      phase_nxt   = phase_e;
      inc_nxt     = inc_e;
      elapsed_nxt = elapsed_e;
      if (elapsed_e > cfg.duration_ticks) begin
        // completion item, sweep goes idle
        q_entry.done = 1'b1;
        running_nxt  = 1'b0;
      end else begin
        q_entry.phase_top = phase_e[PHASE_BITS-1 -: TOP_BITS];
        phase_nxt   = phase_e + inc_e;
        inc_nxt     = inc_e + PHASE_BITS'(cfg.increment_step);
        elapsed_nxt = (elapsed_e == TICK_MAX) ? elapsed_e : elapsed_e + TICK_W'(1);
        running_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      inc_r     <= '0;
      elapsed_r <= '0;
      running_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      inc_r     <= inc_nxt;
      elapsed_r <= elapsed_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

// ===== sv/csag_fifo.sv =====
// ----------------------------------------------------------------------------
// csag_fifo
// Four-entry queue between the tick front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module csag_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  csag_pkg::queue_entry_t push_entry,
  input  logic                   pop,
  output csag_pkg::queue_entry_t pop_entry,
  output logic                   full,
  output logic                   empty
);
  import csag_pkg::*;

  localparam int DEPTH  = 4;
  localparam int PTR_W  = $clog2(DEPTH);

  queue_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]       count_r;
  logic                 do_push, do_pop;

  assign full      = (count_r == (PTR_W + 1)'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/csag_back.sv =====
// ----------------------------------------------------------------------------
// csag_back
// Sine lookup, amplitude scaling, yaw rotation and saturation. Four register
// stages (table read, scale, rotate, output); the whole pipe holds while the
// output item is stalled.
// ----------------------------------------------------------------------------
module csag_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csag_pkg::back_cfg_t    cfg,
  input  logic                   q_empty,
  input  csag_pkg::queue_entry_t q_entry,
  output logic                   q_pop,
  csag_out_if.source             out_ch
);
  import csag_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic                        adv;

  // stage 0: table read
  logic                        s0_valid_r;
  logic                        s0_done_r;
  logic                        s0_neg_r;
  logic [SINE_W-1:0]           s0_sine_r;
  logic [SINE_ADDR_BITS-1:0]   rom_idx;
  logic [1:0]                  quad;

  // stage 1: scaled sample
  logic                        s1_valid_r;
  logic                        s1_done_r;
  logic signed [V_W-1:0]       s1_v_r;
  logic signed [SIN_W-1:0]     sin_s;
  logic signed [PROD_W-1:0]    amp_prod;
  logic signed [PROD_W-1:0]    amp_round;

  // stage 2: rotation products
  logic                        s2_valid_r;
  logic                        s2_done_r;
  logic signed [V_W-1:0]       s2_v_r;
  logic signed [ROT_PROD_W-1:0] s2_pc_r;
  logic signed [ROT_PROD_W-1:0] s2_ps_r;

  // output stage
  logic signed [ROT_SUM_W-1:0] rx, ry;
  logic signed [ROT_SUM_W-1:0] rx_rnd, ry_rnd;
  logic [OUT_BITS-1:0]         ox, oy, oz;
  logic                        out_valid_r;
  logic [OUT_BITS-1:0]         out_x_r, out_y_r, out_z_r;
  logic                        out_done_r;

  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv && !q_empty;

  // quadrant mirror for the quarter-wave table
  assign quad    = q_entry.phase_top[TOP_BITS-1 -: 2];
  assign rom_idx = quad[0] ? ~q_entry.phase_top[SINE_ADDR_BITS-1:0]
                           : q_entry.phase_top[SINE_ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sine_r <= SINE_ROM[rom_idx];
      s0_neg_r  <= quad[1];
      s0_done_r <= q_entry.done;
    end
  end

  always_comb begin
    sin_s     = s0_neg_r ? -$signed({1'b0, s0_sine_r}) : $signed({1'b0, s0_sine_r});
    amp_prod  = PROD_W'(sin_s * $signed({1'b0, cfg.amplitude}));
    amp_round = (amp_prod + PROD_W'(16384)) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v_r    <= amp_round[V_W-1:0];
      s1_done_r <= s0_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pc_r   <= ROT_PROD_W'(cfg.yaw_cos * s1_v_r);
      s2_ps_r   <= ROT_PROD_W'(cfg.yaw_sin * s1_v_r);
      s2_v_r    <= s1_v_r;
      s2_done_r <= s1_done_r;
    end
  end

  // at most one of the x/y inputs of the rotation is nonzero
  always_comb begin
    unique case (axis_t'(cfg.scan_axis))
      AXIS_Y: begin
        rx = -ROT_SUM_W'(s2_ps_r);
        ry = ROT_SUM_W'(s2_pc_r);
      end
      AXIS_Z: begin
        rx = '0;
        ry = '0;
      end
      default: begin
        rx = ROT_SUM_W'(s2_pc_r);
        ry = ROT_SUM_W'(s2_ps_r);
      end
    endcase
    rx_rnd = (rx + ROT_SUM_W'(16384)) >>> 15;
    ry_rnd = (ry + ROT_SUM_W'(16384)) >>> 15;
    ox = sat_out(rx_rnd[ROUND_W-1:0]);
    oy = sat_out(ry_rnd[ROUND_W-1:0]);
    oz = (axis_t'(cfg.scan_axis) == AXIS_Z) ? sat_out(ROUND_W'(s2_v_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r    <= s2_done_r ? '0 : ox;
      out_y_r    <= s2_done_r ? '0 : oy;
      out_z_r    <= s2_done_r ? '0 : oz;
      out_done_r <= s2_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r  <= !q_empty;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accel_x    = out_x_r;
  assign out_ch.accel_y    = out_y_r;
  assign out_ch.accel_z    = out_z_r;
  assign out_ch.sweep_done = out_done_r;

endmodule

// ===== sv/chirp_sweep_accel_generator_core.sv =====
// ----------------------------------------------------------------------------
// chirp_sweep_accel_generator_core
// Linear chirp acceleration generator with yaw rotation.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one tick item (restart flag) per sample period;
// out_ch gives at most one result per tick: x/y/z acceleration in Q4.12,
// saturated, and sweep_done. Ticks while idle without restart give nothing.
// cfg_ch writes the seven registers by index; it is always ready and a
// write to an unused index is dropped. Write registers only while idle.
// Path: queue write, table read, amplitude multiply, rotation multiply,
// output register. Throughput: one tick per cycle while the queue is not
// full, set by the single phase add in the front end and the four-entry
// queue ahead of the arithmetic pipe.
// Reset: sweep idle, phase and increment zero, registers at their defaults;
// no clearing pass, ticks are taken from the first cycle after reset.
// Stall: a held result freezes the back-end pipe; the queue keeps taking
// ticks until it is full, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module chirp_sweep_accel_generator_core (
  input  logic      clk,
  input  logic      rst_n,
  csag_in_if.sink   in_ch,
  csag_out_if.source out_ch,
  csag_cfg_if.sink  cfg_ch
);
  import csag_pkg::*;

  logic [INC_W-1:0]  start_inc_r;
  logic [INC_W-1:0]  inc_step_r;
  logic [AMP_W-1:0]  amplitude_r;
  logic [TICK_W-1:0] duration_r;
  logic [AXIS_W-1:0] axis_r;
  logic [YAW_W-1:0]  yaw_cos_r;
  logic [YAW_W-1:0]  yaw_sin_r;

  front_cfg_t   front_cfg;
  back_cfg_t    back_cfg;
  logic         q_push, q_pop, q_full, q_empty;
  queue_entry_t q_push_entry, q_pop_entry;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_inc_r <= '0;
      inc_step_r  <= '0;
      amplitude_r <= AMP_W'(3277);
      duration_r  <= TICK_W'(6000);
      axis_r      <= AXIS_X;
      yaw_cos_r   <= YAW_W'(32767);
      yaw_sin_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_START_INC: start_inc_r <= cfg_ch.data[INC_W-1:0];
        REG_INC_STEP:  inc_step_r  <= cfg_ch.data[INC_W-1:0];
        REG_AMPLITUDE: amplitude_r <= cfg_ch.data[AMP_W-1:0];
        REG_DURATION:  duration_r  <= cfg_ch.data[TICK_W-1:0];
        REG_SCAN_AXIS: axis_r      <= cfg_ch.data[AXIS_W-1:0];
        REG_YAW_COS:   yaw_cos_r   <= cfg_ch.data[YAW_W-1:0];
        REG_YAW_SIN:   yaw_sin_r   <= cfg_ch.data[YAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    front_cfg.start_increment = start_inc_r;
    front_cfg.increment_step  = inc_step_r;
    front_cfg.duration_ticks  = duration_r;
    back_cfg.amplitude        = amplitude_r;
    back_cfg.scan_axis        = axis_r;
    back_cfg.yaw_cos          = $signed(yaw_cos_r);
    back_cfg.yaw_sin          = $signed(yaw_sin_r);
  end

  csag_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (front_cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_push_entry)
  );

  csag_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  csag_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (back_cfg),
    .q_empty (q_empty),
    .q_entry (q_pop_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== dv/chirp_sweep_accel_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chirp_sweep_accel_generator_core_tb
// Self-checking bench for the chirp sweep acceleration generator. A local
// predictor tracks phase, increment, tick count and the register file, and
// queues the expected accel item for every result-giving tick. Directed sweeps
// hit each axis code, saturating amplitude/yaw and completion; random phases
// reprogram the registers and run restart-driven sweeps under random gaps
// and output stalls.
// ----------------------------------------------------------------------------
module chirp_sweep_accel_generator_core_tb;
  import csag_pkg::*;

  localparam int                   STALL_LIMIT  = 3000;
  localparam int                   PIPE_SETTLE  = 8;
  localparam int                   RANDOM_ITEMS = 1400;
  localparam int                   MAX_PRINTS   = 30;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;
  localparam logic [AXIS_W-1:0]    AXIS_ALIAS_X = 2'd3;
  localparam longint unsigned      HALF_PI_Q30  = 64'd1686629713;

  typedef struct packed {
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
    logic [OUT_BITS-1:0] z;
    logic                done;
  } accel_t;

  logic clk;
  logic rst_n;

  csag_in_if  in_if ();
  csag_out_if out_if ();
  csag_cfg_if cfg_if ();

  chirp_sweep_accel_generator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // predictor state and register copies
  logic [SINE_W-1:0]       sine_q15 [SINE_DEPTH];
  logic [PHASE_BITS-1:0]   chirp_phase;
  logic [PHASE_BITS-1:0]   chirp_inc;
  logic [TICK_W-1:0]       chirp_ticks;
  logic                    chirp_armed;
  logic [INC_W-1:0]        start_inc_q;
  logic [INC_W-1:0]        inc_step_q;
  logic [AMP_W-1:0]        amp_q;
  logic [TICK_W-1:0]       duration_q;
  logic [AXIS_W-1:0]       axis_q;
  logic signed [YAW_W-1:0] yaw_cos_q;
  logic signed [YAW_W-1:0] yaw_sin_q;

  accel_t pending_accel [$];
  int     errors;
  int     results_predicted;
  int     idle_cycles;
  int     gap_mode;
  int     stall_mode;
  int     stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // quarter-wave entry from the Q30 Taylor series, rounded to Q15
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned i);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned t;
    longint unsigned acc;
    longint unsigned q15;
    longint unsigned n;
    ang  = (HALF_PI_Q30 * (2 * longint'(i) + 1)) / (2 * SINE_DEPTH);
    ang2 = (ang * ang) >> 30;
    t    = ang;
    acc  = ang;
    for (n = 1; n <= 8; n++) begin
      t = ((t * ang2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n[0]) acc = acc - t;
      else acc = acc + t;
    end
    q15 = (acc * 32767 + (64'd1 << 29)) >> 30;
    if (q15 > 32767) q15 = 32767;
    return q15[SINE_W-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] clip_out(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[OUT_BITS-1:0];
  endfunction

  function automatic void predict_tick(input logic restart);
    accel_t                    e;
    longint                    m;
    longint                    v;
    longint                    amp;
    longint                    c;
    longint                    s;
    longint                    ax;
    longint                    ay;
    longint                    az;
    logic [TOP_BITS-1:0]       top;
    logic [SINE_ADDR_BITS-1:0] idx;
    if (restart) begin
      chirp_phase = '0;
      chirp_inc   = start_inc_q;
      chirp_ticks = '0;
      chirp_armed = 1'b1;
    end
    if (!chirp_armed) return;
    if (chirp_ticks > duration_q) begin
      chirp_armed = 1'b0;
      e = '{x: '0, y: '0, z: '0, done: 1'b1};
      pending_accel.push_back(e);
      results_predicted++;
      return;
    end
    top = chirp_phase[PHASE_BITS-1 -: TOP_BITS];
    idx = top[SINE_ADDR_BITS-1:0];
    // odd quadrants read the table backwards, upper half is negative
    if (top[SINE_ADDR_BITS]) idx = ~idx;
    m = longint'(sine_q15[idx]);
    if (top[SINE_ADDR_BITS+1]) m = -m;
    amp = longint'(amp_q);
    v = (m * amp + 16384) >>> 15;
    ax = 0;
    ay = 0;
    az = 0;
    case (axis_q)
      AXIS_Y:  ay = v;
      AXIS_Z:  az = v;
      default: ax = v;
    endcase
    c = longint'(yaw_cos_q);
    s = longint'(yaw_sin_q);
    e.x    = clip_out((c * ax - s * ay + 16384) >>> 15);
    e.y    = clip_out((s * ax + c * ay + 16384) >>> 15);
    e.z    = clip_out(az);
    e.done = 1'b0;
    pending_accel.push_back(e);
    results_predicted++;
    chirp_phase = chirp_phase + chirp_inc;
    chirp_inc   = chirp_inc + inc_step_q;
    if (chirp_ticks != TICK_MAX) chirp_ticks = chirp_ticks + TICK_W'(1);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_START_INC: start_inc_q = data[INC_W-1:0];
      REG_INC_STEP:  inc_step_q  = data[INC_W-1:0];
      REG_AMPLITUDE: amp_q       = data[AMP_W-1:0];
      REG_DURATION:  duration_q  = data[TICK_W-1:0];
      REG_SCAN_AXIS: axis_q      = data[AXIS_W-1:0];
      REG_YAW_COS:   yaw_cos_q   = data[YAW_W-1:0];
      REG_YAW_SIN:   yaw_sin_q   = data[YAW_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTS) $display("%0t ns: mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_accel();
    accel_t e;
    if (pending_accel.size() == 0) begin
      report_mismatch("accel item with nothing expected");
      return;
    end
    e = pending_accel.pop_front();
    if (out_if.accel_x !== e.x)
      report_mismatch($sformatf("accel_x %h, expected %h", out_if.accel_x, e.x));
    if (out_if.accel_y !== e.y)
      report_mismatch($sformatf("accel_y %h, expected %h", out_if.accel_y, e.y));
    if (out_if.accel_z !== e.z)
      report_mismatch($sformatf("accel_z %h, expected %h", out_if.accel_z, e.z));
    if (out_if.sweep_done !== e.done)
      report_mismatch($sformatf("sweep_done %b, expected %b", out_if.sweep_done, e.done));
  endtask

  // all three channels are observed here, at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_if.valid && out_if.ready) check_accel();
      if (in_if.valid && in_if.ready) predict_tick(in_if.restart);
      if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.index, cfg_if.data);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_idle(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready = 1'b0;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
      stall_left   = pick_idle(stall_mode);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_tick(input logic restart);
    int gap;
    gap = pick_idle(gap_mode);
    if (gap > 0) begin
      in_if.valid   = 1'b0;
      in_if.restart = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.restart = restart;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // drop valid, drain every expected item, then let the pipe settle
  task automatic wait_pipe_idle();
    in_if.valid = 1'b0;
    while (pending_accel.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_idle_and_defaults();
    gap_mode   = 1;
    stall_mode = 1;
    // no sweep armed until the restart tick: the ticks before it give nothing
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_pipe_idle();
  endtask

  task automatic test_axis_extremes();
    logic [AXIS_W-1:0] axis_codes [4];
    axis_codes = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_ALIAS_X};
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_START_INC, (k < 2) ? 32'h3FF0_0000 : 32'hFFFF_FFFF);
      write_reg(REG_INC_STEP, (k < 2) ? 32'hFFFF_FFFF : 32'h4000_0000);
      write_reg(REG_AMPLITUDE, (k == 3) ? 32'h8000 : 32'hFFFF);
      write_reg(REG_DURATION, 32'd2);
      write_reg(REG_SCAN_AXIS, {30'd0, axis_codes[k]});
      case (k)
        0: begin
          write_reg(REG_YAW_COS, 32'h8000);
          write_reg(REG_YAW_SIN, 32'h7FFF);
        end
        1: begin
          write_reg(REG_YAW_COS, 32'h7FFF);
          write_reg(REG_YAW_SIN, 32'h8000);
        end
        2: begin
          write_reg(REG_YAW_COS, 32'h7FFF);
          write_reg(REG_YAW_SIN, 32'h0000);
        end
        default: begin
          write_reg(REG_YAW_COS, 32'h5A82);
          write_reg(REG_YAW_SIN, 32'hA57E);
        end
      endcase
      // restart sample, two more samples, completion, then an ignored tick
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_pipe_idle();
    end
  endtask

  task automatic program_random_regs();
    logic [TICK_W-1:0] dur;
    if ($urandom_range(0, 1)) write_reg(REG_START_INC, pick_word());
    if ($urandom_range(0, 1)) write_reg(REG_INC_STEP, pick_word());
    if ($urandom_range(0, 1)) write_reg(REG_AMPLITUDE, {16'($urandom()), 16'(pick_word())});
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 19))
        0:       dur = '0;
        1:       dur = '1;
        default: dur = 24'($urandom_range(1, 60));
      endcase
      write_reg(REG_DURATION, {8'($urandom()), dur});
    end
    if ($urandom_range(0, 1))
      write_reg(REG_SCAN_AXIS, {30'($urandom()), 2'($urandom_range(0, 3))});
    if ($urandom_range(0, 1)) write_reg(REG_YAW_COS, {16'($urandom()), 16'(pick_word())});
    if ($urandom_range(0, 1)) write_reg(REG_YAW_SIN, {16'($urandom()), 16'(pick_word())});
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom());
  endtask

  task automatic test_random_sweeps();
    int   goal;
    int   phase_goal;
    logic restart;
    goal = results_predicted + RANDOM_ITEMS;
    while (results_predicted < goal) begin
      program_random_regs();
      gap_mode   = int'($urandom_range(0, 2) != 0);
      stall_mode = int'($urandom_range(0, 2) != 0);
      phase_goal = results_predicted + $urandom_range(20, 80);
      while (results_predicted < phase_goal) begin
        // mostly clean sweeps; occasional restart in the middle of one
        if (chirp_armed) restart = $urandom_range(0, 99) < 3;
        else restart = $urandom_range(0, 99) < 75;
        send_tick(restart);
      end
      wait_pipe_idle();
    end
  endtask

  initial begin
    for (int i = 0; i < SINE_DEPTH; i++) sine_q15[i] = quarter_sine(i);
    start_inc_q       = '0;
    inc_step_q        = '0;
    amp_q             = 16'd3277;
    duration_q        = 24'd6000;
    axis_q            = AXIS_X;
    yaw_cos_q         = 16'sd32767;
    yaw_sin_q         = '0;
    chirp_phase       = '0;
    chirp_inc         = '0;
    chirp_ticks       = '0;
    chirp_armed       = 1'b0;
    errors            = 0;
    results_predicted = 0;
    idle_cycles       = 0;
    gap_mode          = 0;
    stall_mode        = 0;
    in_if.valid       = 1'b0;
    in_if.restart     = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    out_if.ready      = 1'b0;
    rst_n             = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_idle_and_defaults();
    test_axis_extremes();
    test_random_sweeps();

    wait_pipe_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
